/* rtl/sqe_pkg.sv */
// shared constants, codes and controller/datapath interface types
// for the square quadrature engine; no dependencies
package sqe_pkg;

    localparam int MAX_SUB_DEFAULT = 65536;

    localparam int BND_W  = 24;   // signed q8.16 bounds
    localparam int XQ_W   = 40;   // bounds widened to q.32
    localparam int HM_W   = 41;   // step magnitude
    localparam int OFF_W  = 43;   // offset accumulator
    localparam int X_W    = 44;   // sample point
    localparam int TOL_W  = 40;
    localparam int INT_W  = 64;
    localparam int SQ_W   = 48;
    localparam int MACC_W = 106;
    localparam int MAXD_W = 5;
    localparam int ST_W   = 2;
    localparam int SUB_W  = 17;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_ZERO  = 2'd1;
    localparam logic [ST_W-1:0] ST_LIMIT = 2'd2;

    localparam logic [MAXD_W-1:0] MAXD_RESET = 5'd16;

    localparam logic [1:0] SRC_NONE = 2'd0;
    localparam logic [1:0] SRC_PT   = 2'd1;
    localparam logic [1:0] SRC_A    = 2'd2;
    localparam logic [1:0] SRC_B    = 2'd3;

    typedef struct packed {
        logic       load;
        logic       div_start;
        logic [1:0] src;
        logic       pt_first;
        logic       sum_clr;
        logic       sum_half;
        logic       mul_en;
        logic [1:0] mul_step;
        logic       fin;
        logic       save_prev;
        logic       diff;
        logic       rule;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic pipe_empty;
        logic conv;
    } t_stat;

endpackage

/* rtl/sqe_dpath.sv */
// datapath: step divider, sample point pipeline, saturating sum,
// final scaling multiplier and convergence compare; uses sqe_pkg
module sqe_dpath
    import sqe_pkg::*;
#(
    parameter int NW = 17
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic [NW-1:0]           i_n,
    input  logic signed [BND_W-1:0] i_lower_bound,
    input  logic signed [BND_W-1:0] i_upper_bound,
    input  logic [TOL_W-1:0]        i_tolerance,
    output t_stat                   o_stat,
    output logic signed [INT_W-1:0] o_integral
);

    // operands
    logic signed [XQ_W-1:0] r_a, r_b;
    logic                   r_dn;
    logic [HM_W-1:0]        r_dmag;
    logic [TOL_W-1:0]       r_tol;
    logic signed [HM_W-1:0] n_diff;

    // divider
    logic [NW:0]     r_rem;
    logic [HM_W-1:0] r_quo;
    logic [5:0]      r_dcnt;
    logic            r_dbusy;
    logic [NW:0]     rem_sh;
    logic            rem_ge;

    // sample pipeline
    logic [OFF_W-1:0] r_t, off_t, off, step;
    logic [X_W-1:0]   r_x, n_x, a_x, b_x, xm;
    logic [XQ_W-1:0]  r_m;
    logic [39:0]      r_phh, r_phl, r_pll;
    logic [79:0]      sqf;
    logic [SQ_W-1:0]  r_sq;
    logic             r_v1, r_v2, r_v3, r_v4;
    logic [63:0]      r_sum;
    logic [64:0]      sum_add;

    // final multiplier
    logic [31:0]       mul_a, mul_h;
    logic [63:0]       r_pp;
    logic [1:0]        r_psh;
    logic              r_pv, r_pclr;
    logic [MACC_W-1:0] r_macc, macc_base, pp_sh;
    logic [73:0]       q;
    logic [63:0]       lim, mag;

    // estimates
    logic [63:0] r_mag, r_pmag, r_d;
    logic        r_neg, r_pneg;
    logic [64:0] mag_sum;

    // difference of the sign-extended q.32 bounds
    assign n_diff = HM_W'($signed({i_upper_bound, 16'b0}))
                  - HM_W'($signed({i_lower_bound, 16'b0}));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a    <= {i_lower_bound, 16'b0};
            r_b    <= {i_upper_bound, 16'b0};
            r_dn   <= n_diff[HM_W-1];
            r_dmag <= n_diff[HM_W-1] ? HM_W'(-n_diff) : HM_W'(n_diff);
            r_tol  <= i_tolerance;
        end
    end

    // restoring divider, one quotient bit a cycle
    assign rem_sh = {r_rem[NW-1:0], r_quo[HM_W-1]};
    assign rem_ge = rem_sh >= {1'b0, i_n};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_dcnt  <= '0;
        end else if (i_cmd.div_start) begin
            r_dbusy <= 1'b1;
            r_dcnt  <= 6'(HM_W);
            r_rem   <= '0;
            r_quo   <= r_dmag;
        end else if (r_dbusy) begin
            r_rem   <= rem_ge ? (rem_sh - {1'b0, i_n}) : rem_sh;
            r_quo   <= {r_quo[HM_W-2:0], rem_ge};
            r_dcnt  <= r_dcnt - 6'd1;
            r_dbusy <= (r_dcnt != 6'd1);
        end
    end

    // sample point generation
    assign step  = i_cmd.rule ? OFF_W'(r_quo) : {1'b0, r_quo, 1'b0};
    assign off_t = i_cmd.pt_first ? OFF_W'(r_quo) : r_t;
    assign off   = i_cmd.rule ? off_t : (off_t >> 1);
    assign a_x   = X_W'(r_a);
    assign b_x   = X_W'(r_b);

    always_comb begin
        case (i_cmd.src)
            SRC_A:   n_x = a_x;
            SRC_B:   n_x = b_x;
            SRC_PT:  n_x = r_dn ? (a_x - {1'b0, off}) : (a_x + {1'b0, off});
            default: n_x = a_x;
        endcase
    end

    assign xm  = r_x[X_W-1] ? (~r_x + X_W'(1)) : r_x;
    assign sqf = {r_phh, 40'b0} + {19'b0, r_phl, 21'b0} + {40'b0, r_pll};
    assign sum_add = {1'b0, r_sum} + {17'b0, r_sq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= (i_cmd.src != SRC_NONE);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.src == SRC_PT) begin
            r_t <= off_t + step;
        end
        r_x   <= n_x;
        r_m   <= xm[XQ_W-1:0];
        r_phh <= r_m[39:20] * r_m[39:20];
        r_phl <= r_m[39:20] * r_m[19:0];
        r_pll <= r_m[19:0] * r_m[19:0];
        r_sq  <= sqf[79:32];
        if (i_cmd.sum_clr) begin
            r_sum <= '0;
        end else if (i_cmd.sum_half) begin
            r_sum <= r_sum >> 1;
        end else if (r_v4) begin
            r_sum <= sum_add[64] ? '1 : sum_add[63:0];
        end
    end

    // sum times step, 32x32 partial products
    assign mul_a = i_cmd.mul_step[0] ? r_sum[63:32] : r_sum[31:0];
    assign mul_h = i_cmd.mul_step[1] ? {23'b0, r_quo[HM_W-1:32]} : r_quo[31:0];
    assign macc_base = r_pclr ? '0 : r_macc;

    always_comb begin
        case (r_psh)
            2'd1:    pp_sh = {10'b0, r_pp, 32'b0};
            2'd2:    pp_sh = {r_pp[41:0], 64'b0};
            default: pp_sh = {42'b0, r_pp};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pp   <= mul_a * mul_h;
        r_psh  <= 2'(i_cmd.mul_step[0]) + 2'(i_cmd.mul_step[1]);
        r_pclr <= (i_cmd.mul_step == 2'd0);
        if (r_pv) begin
            r_macc <= macc_base + pp_sh;
        end
    end

    assign q   = r_macc[MACC_W-1:32];
    assign lim = r_dn ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    assign mag = (q > {10'b0, lim}) ? lim : q[63:0];
    assign mag_sum = {1'b0, r_mag} + {1'b0, r_pmag};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag      <= '0;
            r_neg      <= 1'b0;
            o_integral <= '0;
        end else if (i_cmd.fin) begin
            r_mag      <= mag;
            r_neg      <= r_dn && (mag != 64'd0);
            o_integral <= (r_dn && (mag != 64'd0)) ? -mag : mag;
        end
        if (i_cmd.save_prev) begin
            r_pmag <= r_mag;
            r_pneg <= r_neg;
        end
        if (i_cmd.diff) begin
            if (r_pneg == r_neg) begin
                r_d <= (r_mag > r_pmag) ? (r_mag - r_pmag) : (r_pmag - r_mag);
            end else begin
                r_d <= mag_sum[64] ? '1 : mag_sum[63:0];
            end
        end
    end

    assign o_stat.div_busy   = r_dbusy;
    assign o_stat.pipe_empty = !(r_v1 || r_v2 || r_v3 || r_v4);
    assign o_stat.conv       = r_d <= {24'b0, r_tol};

endmodule

/* rtl/sqe_ctrl.sv */
// controller: request sequencing, subinterval count, doubling loop
// and result handshake; uses sqe_pkg
module sqe_ctrl
    import sqe_pkg::*;
#(
    parameter int MAX_SUBINTERVALS = MAX_SUB_DEFAULT,
    parameter int NW               = 17
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_func,
    input  logic              i_adaptive,
    input  logic [SUB_W-1:0]  i_subintervals,
    input  logic [MAXD_W-1:0] i_max_doublings,
    output t_cmd              o_cmd,
    output logic [NW-1:0]     o_n,
    input  t_stat             i_stat,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [ST_W-1:0]   o_status,
    output logic [MAXD_W-1:0] o_doublings_used
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_ENDA  = 4'd3;
    localparam logic [3:0] S_ENDB  = 4'd4;
    localparam logic [3:0] S_ENDW  = 4'd5;
    localparam logic [3:0] S_PTS   = 4'd6;
    localparam logic [3:0] S_DRAIN = 4'd7;
    localparam logic [3:0] S_MUL   = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;
    localparam logic [3:0] S_DIFF  = 4'd10;
    localparam logic [3:0] S_CMP   = 4'd11;
    localparam logic [3:0] S_LIM   = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    localparam logic [NW:0] MAX_N = (NW+1)'(MAX_SUBINTERVALS);

    logic [3:0]        r_state, n_state;
    logic [NW-1:0]     r_n, n_n, r_cnt, n_cnt, clamp_n;
    logic [MAXD_W-1:0] r_used, n_used;
    logic [ST_W-1:0]   r_status, n_status;
    logic [2:0]        r_step, n_step;
    logic              r_rule, n_rule, r_adapt, n_adapt;
    logic              r_first_pt, n_first_pt, r_first_est, n_first_est;

    assign clamp_n = (32'(i_subintervals) > 32'(MAX_SUBINTERVALS))
                   ? NW'(MAX_SUBINTERVALS) : NW'(i_subintervals);

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_cnt       = r_cnt;
        n_used      = r_used;
        n_status    = r_status;
        n_step      = r_step;
        n_rule      = r_rule;
        n_adapt     = r_adapt;
        n_first_pt  = r_first_pt;
        n_first_est = r_first_est;
        o_cmd       = '0;
        o_cmd.rule  = r_rule;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load  = 1'b1;
                    n_rule      = i_func;
                    n_adapt     = i_adaptive;
                    n_used      = '0;
                    n_first_est = 1'b1;
                    if (!i_adaptive && (i_subintervals == '0)) begin
                        n_status = ST_ZERO;
                        n_state  = S_OUT;
                    end else begin
                        n_status = ST_OK;
                        n_n      = i_adaptive ? NW'(1) : clamp_n;
                        n_state  = S_START;
                    end
                end
            end
            S_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.sum_clr   = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (!i_stat.div_busy) begin
                    n_first_pt = 1'b1;
                    n_cnt      = r_rule ? (r_n - NW'(1)) : r_n;
                    n_state    = r_rule ? S_ENDA : S_PTS;
                end
            end
            S_ENDA: begin
                o_cmd.src = SRC_A;
                n_state   = S_ENDB;
            end
            S_ENDB: begin
                o_cmd.src = SRC_B;
                n_state   = S_ENDW;
            end
            S_ENDW: begin
                if (i_stat.pipe_empty) begin
                    o_cmd.sum_half = 1'b1;
                    n_state        = S_PTS;
                end
            end
            S_PTS: begin
                if (r_cnt == '0) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.src      = SRC_PT;
                    o_cmd.pt_first = r_first_pt;
                    n_first_pt     = 1'b0;
                    n_cnt          = r_cnt - NW'(1);
                end
            end
            S_DRAIN: begin
                if (i_stat.pipe_empty) begin
                    n_step  = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // four partial products, then the last add before S_FIN
                if (r_step[2]) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.mul_en   = 1'b1;
                    o_cmd.mul_step = r_step[1:0];
                    n_step         = r_step + 3'd1;
                end
            end
            S_FIN: begin
                o_cmd.fin   = 1'b1;
                n_first_est = 1'b0;
                if (!r_adapt) begin
                    n_state = S_OUT;
                end else if (r_first_est) begin
                    n_state = S_LIM;
                end else begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_CMP;
            end
            S_CMP: begin
                n_state = i_stat.conv ? S_OUT : S_LIM;
            end
            S_LIM: begin
                if ((r_used >= i_max_doublings) || (({1'b0, r_n} << 1) > MAX_N)) begin
                    n_status = ST_LIMIT;
                    n_state  = S_OUT;
                end else begin
                    o_cmd.save_prev = 1'b1;
                    n_n             = r_n << 1;
                    n_used          = r_used + MAXD_W'(1);
                    n_state         = S_START;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_cnt       <= n_cnt;
        r_used      <= n_used;
        r_status    <= n_status;
        r_step      <= n_step;
        r_rule      <= n_rule;
        r_adapt     <= n_adapt;
        r_first_pt  <= n_first_pt;
        r_first_est <= n_first_est;
    end

    assign o_n              = r_n;
    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = (r_state == S_OUT);
    assign o_status         = r_status;
    assign o_doublings_used = r_used;

endmodule

/* rtl/square_quadrature_engine_core.sv */
// top level of the square quadrature engine: config register,
// controller and datapath; uses sqe_pkg, sqe_ctrl, sqe_dpath
//
// integrates f(x) = x*x from i_lower_bound to i_upper_bound (signed q8.16)
// by the midpoint rule (i_func 0) or the trapezoid rule (i_func 1)
// input channel: i_valid / o_stall, one request per beat
// output channel: o_valid / i_stall, one result beat per request
// one request is handled at a time; o_stall is high from acceptance until
// the result beat has been taken
// one estimate with n subintervals runs the bit-serial step divider, then feeds
// the samples through the squaring pipeline, one sample per cycle (the trapezoid
// rule first issues and drains its two ends), then drains the pipeline and
// accumulates the partial products of the final scaling
// fixed mode: the result beat follows a single estimate
// zero count in fixed mode: result beat in the cycle after acceptance
// adaptive mode: estimates for n = 2^k, k = 0..doublings, each later one compared with the one before
// the result waits in its registers for as long as i_stall is held
// reset (i_rst_n low, synchronous) returns to idle, drops any request
// in flight and sets max_doublings to 16
// i_cfg_wr_en writes max_doublings; write it only while the block is idle
module square_quadrature_engine_core
    import sqe_pkg::*;
#(
    parameter int MAX_SUBINTERVALS = MAX_SUB_DEFAULT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_func,
    input  logic                    i_adaptive,
    input  logic signed [BND_W-1:0] i_lower_bound,
    input  logic signed [BND_W-1:0] i_upper_bound,
    input  logic [SUB_W-1:0]        i_subintervals,
    input  logic [TOL_W-1:0]        i_tolerance,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [INT_W-1:0] o_integral,
    output logic [ST_W-1:0]         o_status,
    output logic [MAXD_W-1:0]       o_doublings_used,
    input  logic                    i_cfg_wr_en,
    input  logic [MAXD_W-1:0]       i_cfg_wr_data
);

    // subinterval count width follows the largest count
    localparam int NW = $clog2(MAX_SUBINTERVALS + 1);

    logic [MAXD_W-1:0] r_max_doublings;
    t_cmd              cmd;
    t_stat             stat;
    logic [NW-1:0]     n_cur;

    // max_doublings register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_doublings <= MAXD_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_doublings <= i_cfg_wr_data;
        end
    end

    sqe_ctrl #(
        .MAX_SUBINTERVALS (MAX_SUBINTERVALS),
        .NW               (NW)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_adaptive       (i_adaptive),
        .i_subintervals   (i_subintervals),
        .i_max_doublings  (r_max_doublings),
        .o_cmd            (cmd),
        .o_n              (n_cur),
        .i_stat           (stat),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_doublings_used (o_doublings_used)
    );

    sqe_dpath #(
        .NW (NW)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_n           (n_cur),
        .i_lower_bound (i_lower_bound),
        .i_upper_bound (i_upper_bound),
        .i_tolerance   (i_tolerance),
        .o_stat        (stat),
        .o_integral    (o_integral)
    );

endmodule

/* rtl/sqe_checker.sv */
// port-level checks for square_quadrature_engine_core, bound to it
// uses sqe_pkg
module sqe_checker
    import sqe_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_stall,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic signed [INT_W-1:0] o_integral,
    input logic [ST_W-1:0]         o_status,
    input logic [MAXD_W-1:0]       o_doublings_used
);

    // a held result beat keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_integral) && $stable(o_status))
        else $error("result changed while stalled");

    // no new request is taken while a result is pending
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while result pending");

    // zero subinterval count gives an empty result
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_ZERO) |-> (o_integral == '0) && (o_doublings_used == '0))
        else $error("zero count result not empty");

    // a result beat taken leaves the output idle next cycle
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |=> !o_valid)
        else $error("result repeated");

endmodule

bind square_quadrature_engine_core sqe_checker u_sqe_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_integral       (o_integral),
    .o_status         (o_status),
    .o_doublings_used (o_doublings_used)
);
